// File: rtl/torq_pkg.sv
// Package for the timestamp-ordered request queue.
// Holds the request and grant word types and the cell control struct.
// No dependencies.
`default_nettype none

package torq_pkg;

	localparam int IdW    = 6;
	localparam int StampW = 16;
	localparam int PosW   = 5;

	typedef struct packed {
		logic [IdW-1:0]    requester;
		logic [StampW-1:0] stamp;
		logic              final_request;
	} request_t;

	typedef struct packed {
		logic [IdW-1:0]    granted;
		logic [StampW-1:0] granted_stamp;
		logic [PosW-1:0]   position;
		logic              end_of_grants;
		logic              overflowed;
	} grant_t;

	// Broadcast to every cell of the chain.
	typedef struct packed {
		logic load;  // insert the broadcast request
		logic shift; // move every entry one cell toward the head
	} cell_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/torq_cell.sv
// One cell of the sorted insertion chain: holds one queue entry.
// Depends on torq_pkg for the control struct and the id width.
`default_nettype none

module torq_cell #(
	parameter int STAMP_W = 16
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  torq_pkg::cell_ctrl_t     ctrl,
	input  wire [torq_pkg::IdW-1:0]  new_id,
	input  wire [STAMP_W-1:0]        new_stamp,
	input  wire                      prev_ins,
	input  wire                      prev_valid,
	input  wire [torq_pkg::IdW-1:0]  prev_id,
	input  wire [STAMP_W-1:0]        prev_stamp,
	input  wire                      next_valid,
	input  wire [torq_pkg::IdW-1:0]  next_id,
	input  wire [STAMP_W-1:0]        next_stamp,
	output logic                     ins,
	output logic                     valid,
	output logic [torq_pkg::IdW-1:0] id,
	output logic [STAMP_W-1:0]       stamp
);
	import torq_pkg::*;

	logic               valid_q;
	logic [IdW-1:0]     id_q;
	logic [STAMP_W-1:0] stamp_q;

	// A cell is displaced by the new request when it is empty or holds a
	// strictly later stamp, so equal stamps keep their arrival order.
	assign ins = !valid_q || (stamp_q > new_stamp);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			valid_q <= next_valid;
		end else if (ctrl.load && ins) begin
			valid_q <= prev_ins ? prev_valid : 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			id_q    <= next_id;
			stamp_q <= next_stamp;
		end else if (ctrl.load && ins) begin
			if (prev_ins) begin
				id_q    <= prev_id;
				stamp_q <= prev_stamp;
			end else begin
				id_q    <= new_id;
				stamp_q <= new_stamp;
			end
		end
	end

	assign valid = valid_q;
	assign id    = id_q;
	assign stamp = stamp_q;

endmodule

`default_nettype wire

// File: rtl/timestamp_ordered_request_queue.sv
// Top level of the timestamp-ordered request queue: a chain of torq_cell
// entries kept in stamp order, plus the grant sequencer.
// Depends on torq_pkg and torq_cell.
//
// Usage: a request word is taken at a rising edge where start is high and
// busy is low. Each request is placed into its sorted position in the cell
// chain in that same cycle, so requests may be issued back to back, one per
// cycle while busy is low. A request that finds the queue full is dropped
// and the batch is flagged as overflowed. The request marked final_request
// is inserted the same way and then starts the grants: busy goes high, and
// while it is high valid is high for one grant word per cycle, head of the
// queue first, with position counting up from zero, until every held entry
// is granted, each grant shifting the cell chain one entry toward the head.
// The last grant word carries end_of_grants; busy drops after it and the
// queue is empty for the next batch. The receiver cannot stall: each grant
// word is present for exactly one cycle. Reset empties the queue and clears
// the overflow flag; no clearing pass is needed.
`default_nettype none

module timestamp_ordered_request_queue #(
	parameter int QUEUE_DEPTH = 32,
	parameter int STAMP_BITS  = 16
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	input  torq_pkg::request_t req,
	output logic               busy,
	output logic               valid,
	output torq_pkg::grant_t   result
);
	import torq_pkg::*;

	localparam int KeptW  = (STAMP_BITS < StampW) ? STAMP_BITS : StampW;
	localparam int CountW = $clog2(QUEUE_DEPTH + 1);

	cell_ctrl_t ctrl;

	logic [QUEUE_DEPTH-1:0] ins;
	logic [QUEUE_DEPTH-1:0] cvalid;
	logic [IdW-1:0]         cid   [QUEUE_DEPTH];
	logic [KeptW-1:0]       cstamp[QUEUE_DEPTH];

	logic [CountW-1:0] count_q;
	logic [PosW-1:0]   pos_q;
	logic              drain_q;
	logic              dropped_q;

	logic             accept;
	logic             full;
	logic [KeptW-1:0] new_stamp;

	assign accept    = start && !busy;
	assign full      = (count_q == CountW'(QUEUE_DEPTH));
	assign new_stamp = req.stamp[KeptW-1:0];

	assign ctrl.load  = accept && !full;
	assign ctrl.shift = drain_q;

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic             p_ins;
		logic             p_valid;
		logic [IdW-1:0]   p_id;
		logic [KeptW-1:0] p_stamp;
		logic             n_valid;
		logic [IdW-1:0]   n_id;
		logic [KeptW-1:0] n_stamp;

		if (i == 0) begin : g_head
			assign p_ins   = 1'b0;
			assign p_valid = 1'b0;
			assign p_id    = '0;
			assign p_stamp = '0;
		end else begin : g_body
			assign p_ins   = ins[i-1];
			assign p_valid = cvalid[i-1];
			assign p_id    = cid[i-1];
			assign p_stamp = cstamp[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign n_valid = 1'b0;
			assign n_id    = '0;
			assign n_stamp = '0;
		end else begin : g_inner
			assign n_valid = cvalid[i+1];
			assign n_id    = cid[i+1];
			assign n_stamp = cstamp[i+1];
		end

		torq_cell #(
			.STAMP_W(KeptW)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.new_id    (req.requester),
			.new_stamp (new_stamp),
			.prev_ins  (p_ins),
			.prev_valid(p_valid),
			.prev_id   (p_id),
			.prev_stamp(p_stamp),
			.next_valid(n_valid),
			.next_id   (n_id),
			.next_stamp(n_stamp),
			.ins       (ins[i]),
			.valid     (cvalid[i]),
			.id        (cid[i]),
			.stamp     (cstamp[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			pos_q     <= '0;
			drain_q   <= 1'b0;
			dropped_q <= 1'b0;
		end else if (drain_q) begin
			count_q <= count_q - 1'b1;
			pos_q   <= pos_q + 1'b1;
			if (count_q == CountW'(1)) begin
				drain_q   <= 1'b0;
				dropped_q <= 1'b0;
			end
		end else if (accept) begin
			if (full) begin
				dropped_q <= 1'b1;
			end else begin
				count_q <= count_q + 1'b1;
			end
			if (req.final_request) begin
				drain_q <= 1'b1;
				pos_q   <= '0;
			end
		end
	end

	// The head cell always holds the next grant while draining.
	always_comb begin
		logic [StampW-1:0] st_ext;
		st_ext                = '0;
		st_ext[KeptW-1:0]     = cstamp[0];
		result.granted        = cid[0];
		result.granted_stamp  = st_ext;
		result.position       = pos_q;
		result.end_of_grants  = (count_q == CountW'(1));
		result.overflowed     = dropped_q;
	end

	assign busy  = drain_q;
	assign valid = drain_q;

	a_grant_has_entry: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> (cvalid[0] && count_q != '0))
		else $error("grant word issued from an empty head cell");

	a_end_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && result.end_of_grants) |=> (!busy && count_q == '0 && !cvalid[0]))
		else $error("queue not empty after the last grant word");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CountW'(QUEUE_DEPTH))
		else $error("entry count above queue depth");

	a_final_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.final_request) |=> (valid && result.position == '0))
		else $error("final request did not start the grants");

endmodule

`default_nettype wire
